FILE: rtl/ptalloc_pkg.sv
// ----------------------------------------------------------------------------
// ptalloc_pkg
// types and constants shared by the page table allocator
// ----------------------------------------------------------------------------
package ptalloc_pkg;

    localparam logic [3:0] OP_ALLOC = 4'd0;
    localparam logic [3:0] OP_MAP   = 4'd1;
    localparam logic [3:0] OP_FINDA = 4'd2;
    localparam logic [3:0] OP_INVAL = 4'd3;
    localparam logic [3:0] OP_ALLRD = 4'd4;
    localparam logic [3:0] OP_ALLW  = 4'd5;
    localparam logic [3:0] OP_PAGEW = 4'd6;
    localparam logic [3:0] OP_REL   = 4'd7;
    localparam logic [3:0] OP_QUERY = 4'd8;
    localparam logic [3:0] OP_FINDP = 4'd9;
    localparam logic [3:0] OP_REMAP = 4'd10;
    localparam logic [3:0] OP_SETC  = 4'd11;
    localparam logic [3:0] OP_READ  = 4'd12;

    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [5:0]  page_count;
        logic [15:0] alloc_id_base;
        logic [15:0] alloc_sel;
        logic [15:0] page_id;
        logic [15:0] frame_address;
        logic [4:0]  entry_index;
        logic        flag_value;
    } req_t;

    typedef struct packed {
        logic [15:0] new_alloc_id;
        logic [15:0] result_page;
        logic [4:0]  result_index;
        logic [15:0] result_address;
        logic        ok;
        logic        entry_allocated;
        logic        entry_valid;
        logic        writable;
        logic        entry_copied;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARUN,
        ST_AWRITE,
        ST_SCAN,
        ST_RDIX,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/page_table_allocator_top.sv
// ----------------------------------------------------------------------------
// page_table_allocator_top
// first-fit page table with copy-on-write marks, one request at a time
// ----------------------------------------------------------------------------
// channel  dir  handshake          word
// req      in   req_valid/stall    ptalloc_pkg::req_t
// rsp      out  rsp_valid/stall    ptalloc_pkg::rsp_t
//
// search requests sweep the table once, one entry a cycle unless paused
// allocate sweeps for a free run, then writes it
// invalidate, set copied, all read: applied when taken; read entry: via ST_RDIX
// release pauses its sweep while a result word is held by rsp_stall
// reset clears all marks at once, no clearing pass
// ----------------------------------------------------------------------------
module page_table_allocator_top #(
    parameter int TABLE_ENTRIES = 32,
    parameter int ID_BITS       = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ptalloc_pkg::req_t   req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ptalloc_pkg::rsp_t   rsp
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    ptalloc_pkg::state_t state_reg, state_next;
    ptalloc_pkg::req_t   req_reg, req_next;
    ptalloc_pkg::rsp_t   res_reg, res_next;
    ptalloc_pkg::rsp_t   out_reg, out_word;
    logic                out_valid_reg, out_load;

    logic [TABLE_ENTRIES-1:0] alloc_reg, alloc_next;
    logic [TABLE_ENTRIES-1:0] mapped_reg, mapped_next;
    logic [TABLE_ENTRIES-1:0] write_reg, write_next;
    logic [TABLE_ENTRIES-1:0] copied_reg, copied_next;
    logic [TABLE_ENTRIES-1:0] idw_reg, idw_next;
    logic [TABLE_ENTRIES-1:0] frw_reg, frw_next;

    logic [IW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      run_reg, run_next, run_n;
    logic [5:0]         rem_reg, rem_next;
    logic [ID_BITS-1:0] p_reg, p_next, p_n;
    logic               found_reg, found_next;
    logic [5:0]         n_reg, n_next;

    logic [2*ID_BITS-1:0] id_mem [TABLE_ENTRIES];
    logic [15:0]          fr_mem [TABLE_ENTRIES];
    logic [2*ID_BITS-1:0] rd_id_reg;
    logic [15:0]          rd_fr_reg;
    logic [IW-1:0]        raddr, waddr;
    logic                 id_we, fr_we;
    logic [2*ID_BITS-1:0] id_wdata;

    logic [31:0]        sel32, pg32, base32, ix_in32, ix_r32, k32, pge32, aid32, pn32;
    logic [ID_BITS-1:0] sel_m, pg_m, aid;
    logic [ID_BITS-1:0] pg_e, ow_e;
    logic [15:0]        fr_e;
    logic               a_e, m_e, w_e, c_e;
    logic               oready, cnt_ok_in, ix_ok_in, ix_ok_r, go, rel_hit;
    logic [IW-1:0]      ix_in;

    assign sel32   = 32'(req_reg.alloc_sel);
    assign pg32    = 32'(req_reg.page_id);
    assign base32  = 32'(req_reg.alloc_id_base);
    assign sel_m   = sel32[ID_BITS-1:0];
    assign pg_m    = pg32[ID_BITS-1:0];
    assign aid     = base32[ID_BITS-1:0] + ID_BITS'(1);
    assign aid32   = 32'(aid);
    assign ix_in32 = 32'(req.entry_index);
    assign ix_in   = ix_in32[IW-1:0];
    assign ix_r32  = 32'(req_reg.entry_index);
    assign ix_ok_in = ix_in32 < 32'(TABLE_ENTRIES);
    assign ix_ok_r  = ix_r32 < 32'(TABLE_ENTRIES);
    assign cnt_ok_in = (req.page_count != 6'd0)
                    && (32'(req.page_count) <= 32'(TABLE_ENTRIES));
    assign k32     = 32'(idx_reg);

    assign a_e  = alloc_reg[idx_reg];
    assign m_e  = mapped_reg[idx_reg];
    assign w_e  = write_reg[idx_reg];
    assign c_e  = copied_reg[idx_reg];
    assign pg_e = idw_reg[idx_reg] ? rd_id_reg[2*ID_BITS-1:ID_BITS] : '1;
    assign ow_e = idw_reg[idx_reg] ? rd_id_reg[ID_BITS-1:0] : '1;
    assign fr_e = frw_reg[idx_reg] ? rd_fr_reg : 16'hFFFF;
    assign pge32 = 32'(pg_e);
    assign run_n = a_e ? '0 : run_reg + CW'(1);
    assign p_n   = p_reg + ID_BITS'(1);
    assign pn32  = 32'(p_n);

    assign oready  = !out_valid_reg || !rsp_stall;
    assign rel_hit = a_e && (ow_e == sel_m) && m_e && (w_e || req_reg.flag_value)
                  && (32'(n_reg) < 32'(ptalloc_pkg::MAX_RESULTS));
    assign go = (req_reg.opcode != ptalloc_pkg::OP_REL) || oready;

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[waddr] <= id_wdata;
        end
        if (fr_we)
        begin
            fr_mem[waddr] <= req_reg.frame_address;
        end
        rd_id_reg <= id_mem[raddr];
        rd_fr_reg <= fr_mem[raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        alloc_next  = alloc_reg;
        mapped_next = mapped_reg;
        write_next  = write_reg;
        copied_next = copied_reg;
        idw_next    = idw_reg;
        frw_next    = frw_reg;
        idx_next    = idx_reg;
        run_next    = run_reg;
        rem_next    = rem_reg;
        p_next      = p_reg;
        found_next  = found_reg;
        n_next      = n_reg;
        raddr       = idx_reg;
        waddr       = idx_reg;
        id_we       = 1'b0;
        fr_we       = 1'b0;
        id_wdata    = {p_n, aid};
        out_load    = 1'b0;
        out_word    = res_reg;
        case (state_reg)
            ptalloc_pkg::ST_IDLE:
            begin
                raddr = (req.opcode == ptalloc_pkg::OP_READ) ? ix_in : '0;
                if (req_valid)
                begin
                    req_next      = req;
                    res_next      = '0;
                    res_next.last = 1'b1;
                    found_next    = 1'b0;
                    n_next        = '0;
                    idx_next      = '0;
                    run_next      = '0;
                    state_next    = ptalloc_pkg::ST_FINISH;
                    case (req.opcode)
                        ptalloc_pkg::OP_ALLOC:
                        begin
                            if (cnt_ok_in)
                            begin
                                state_next = ptalloc_pkg::ST_ARUN;
                            end
                        end
                        ptalloc_pkg::OP_MAP, ptalloc_pkg::OP_FINDA,
                        ptalloc_pkg::OP_ALLW, ptalloc_pkg::OP_PAGEW,
                        ptalloc_pkg::OP_REL, ptalloc_pkg::OP_FINDP,
                        ptalloc_pkg::OP_REMAP:
                        begin
                            state_next = ptalloc_pkg::ST_SCAN;
                        end
                        ptalloc_pkg::OP_QUERY:
                        begin
                            res_next.ok       = 1'b1;
                            res_next.writable = 1'b1;
                            state_next        = ptalloc_pkg::ST_SCAN;
                        end
                        ptalloc_pkg::OP_INVAL:
                        begin
                            if (ix_ok_in)
                            begin
                                mapped_next[ix_in] = 1'b0;
                                res_next.ok        = 1'b1;
                            end
                        end
                        ptalloc_pkg::OP_ALLRD:
                        begin
                            write_next  = '0;
                            res_next.ok = 1'b1;
                        end
                        ptalloc_pkg::OP_SETC:
                        begin
                            if (ix_ok_in)
                            begin
                                copied_next[ix_in] = req.flag_value;
                                res_next.ok        = 1'b1;
                            end
                        end
                        ptalloc_pkg::OP_READ:
                        begin
                            idx_next   = ix_in;
                            state_next = ptalloc_pkg::ST_RDIX;
                        end
                        default:
                        begin
                            state_next = ptalloc_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            ptalloc_pkg::ST_ARUN:
            begin
                run_next = run_n;
                if (32'(run_n) == 32'(req_reg.page_count))
                begin
                    idx_next   = IW'(k32 + 32'd1 - 32'(run_n));
                    rem_next   = req_reg.page_count;
                    p_next     = pg_m;
                    state_next = ptalloc_pkg::ST_AWRITE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ptalloc_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ptalloc_pkg::ST_AWRITE:
            begin
                id_we                = 1'b1;
                alloc_next[idx_reg]  = 1'b1;
                write_next[idx_reg]  = 1'b1;
                idw_next[idx_reg]    = 1'b1;
                p_next               = p_n;
                rem_next             = rem_reg - 6'd1;
                idx_next             = idx_reg + IW'(1);
                if (rem_reg == 6'd1)
                begin
                    res_next.new_alloc_id = aid32[15:0];
                    res_next.result_page  = pn32[15:0];
                    res_next.ok           = 1'b1;
                    state_next            = ptalloc_pkg::ST_FINISH;
                end
            end
            ptalloc_pkg::ST_SCAN:
            begin
                if (go)
                begin
                    raddr = idx_reg + IW'(1);
                    idx_next = idx_reg + IW'(1);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ptalloc_pkg::ST_FINISH;
                    end
                    case (req_reg.opcode)
                        ptalloc_pkg::OP_MAP:
                        begin
                            if (a_e && !m_e && ow_e == sel_m && !found_reg)
                            begin
                                fr_we                 = 1'b1;
                                frw_next[idx_reg]     = 1'b1;
                                mapped_next[idx_reg]  = 1'b1;
                                res_next.result_page  = pge32[15:0];
                                res_next.result_index = k32[4:0];
                                res_next.ok           = 1'b1;
                                found_next            = 1'b1;
                            end
                        end
                        ptalloc_pkg::OP_FINDA:
                        begin
                            if (m_e && fr_e == req_reg.frame_address && !found_reg)
                            begin
                                res_next.result_index = k32[4:0];
                                res_next.ok           = 1'b1;
                                found_next            = 1'b1;
                            end
                        end
                        ptalloc_pkg::OP_ALLW:
                        begin
                            if (a_e && ow_e == sel_m)
                            begin
                                write_next[idx_reg] = 1'b1;
                                res_next.ok         = 1'b1;
                            end
                        end
                        ptalloc_pkg::OP_PAGEW:
                        begin
                            if (a_e && pg_e == pg_m && !found_reg)
                            begin
                                write_next[idx_reg] = 1'b1;
                                res_next.ok         = 1'b1;
                                found_next          = 1'b1;
                            end
                        end
                        ptalloc_pkg::OP_REL:
                        begin
                            if (a_e && ow_e == sel_m)
                            begin
                                alloc_next[idx_reg]  = 1'b0;
                                mapped_next[idx_reg] = 1'b0;
                                copied_next[idx_reg] = 1'b0;
                            end
                            if (rel_hit)
                            begin
                                if (n_reg != 6'd0)
                                begin
                                    out_load      = 1'b1;
                                    out_word      = res_reg;
                                    out_word.last = 1'b0;
                                end
                                res_next                = '0;
                                res_next.result_index   = k32[4:0];
                                res_next.result_address = fr_e;
                                res_next.ok             = 1'b1;
                                res_next.last           = 1'b1;
                                n_next                  = n_reg + 6'd1;
                            end
                        end
                        ptalloc_pkg::OP_QUERY:
                        begin
                            if (a_e && ow_e == sel_m && c_e)
                            begin
                                res_next.writable = 1'b0;
                            end
                        end
                        ptalloc_pkg::OP_FINDP:
                        begin
                            if (a_e && pg_e == pg_m && !found_reg)
                            begin
                                res_next.result_page  = req_reg.page_id;
                                res_next.result_index = k32[4:0];
                                res_next.ok           = 1'b1;
                                found_next            = 1'b1;
                            end
                        end
                        ptalloc_pkg::OP_REMAP:
                        begin
                            if (a_e && pg_e == pg_m)
                            begin
                                fr_we                = 1'b1;
                                frw_next[idx_reg]    = 1'b1;
                                write_next[idx_reg]  = 1'b1;
                                mapped_next[idx_reg] = 1'b1;
                                if (!found_reg)
                                begin
                                    res_next.result_page  = req_reg.page_id;
                                    res_next.result_index = k32[4:0];
                                    res_next.ok           = 1'b1;
                                    found_next            = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            res_next = res_reg;
                        end
                    endcase
                end
            end
            ptalloc_pkg::ST_RDIX:
            begin
                if (ix_ok_r)
                begin
                    res_next.result_page     = pge32[15:0];
                    res_next.result_index    = req_reg.entry_index;
                    res_next.result_address  = fr_e;
                    res_next.ok              = 1'b1;
                    res_next.entry_allocated = a_e;
                    res_next.entry_valid     = m_e;
                    res_next.writable        = w_e;
                    res_next.entry_copied    = c_e;
                end
                state_next = ptalloc_pkg::ST_FINISH;
            end
            ptalloc_pkg::ST_FINISH:
            begin
                if (oready)
                begin
                    out_load   = 1'b1;
                    out_word   = res_reg;
                    state_next = ptalloc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptalloc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptalloc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            alloc_reg     <= '0;
            mapped_reg    <= '0;
            write_reg     <= '0;
            copied_reg    <= '0;
            idw_reg       <= '0;
            frw_reg       <= '0;
            idx_reg       <= '0;
            run_reg       <= '0;
            rem_reg       <= '0;
            found_reg     <= 1'b0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && rsp_stall);
            alloc_reg     <= alloc_next;
            mapped_reg    <= mapped_next;
            write_reg     <= write_next;
            copied_reg    <= copied_next;
            idw_reg       <= idw_next;
            frw_reg       <= frw_next;
            idx_reg       <= idx_next;
            run_reg       <= run_next;
            rem_reg       <= rem_next;
            found_reg     <= found_next;
            n_reg         <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        p_reg   <= p_next;
        if (out_load)
        begin
            out_reg <= out_word;
        end
    end

    assign req_stall = (state_reg != ptalloc_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_mapped_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (mapped_reg & ~alloc_reg) == '0)
        else $error("mapped entry not allocated");

    a_mapped_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (mapped_reg & ~frw_reg) == '0)
        else $error("mapped entry without stored frame");

    a_alloc_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (alloc_reg & ~idw_reg) == '0)
        else $error("allocated entry without stored ids");

    a_rel_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= 32'(ptalloc_pkg::MAX_RESULTS))
        else $error("release result count overflow");

endmodule
